// ===== sv/pdnl_pkg.sv =====
// Shared types and constants for the PD acceleration command block.
// Holds field widths, register indexes and the pipeline payload structs.
// No dependencies.
package pdnl_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int IN_W     = 32;   // input field width
    localparam int GAIN_W   = 24;   // register width
    localparam int PROD_W   = 57;   // signed 32 x unsigned 24 product
    localparam int MAG_W    = 32;   // magnitude of saturated feedback
    localparam int SQ_W     = 64;   // squares and sum of squares
    localparam int NUM_W    = 56;   // magnitude times limit
    localparam int ROOT_W   = 32;   // square root result
    localparam int REM_W    = 34;   // square root remainder
    localparam int QUO_W    = 24;   // scaled magnitude, at most the limit
    localparam int DREM_W   = 32;   // divider remainder, below the norm
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_X         = 3'd0,
        REG_KP_Y         = 3'd1,
        REG_KP_Z         = 3'd2,
        REG_KV_X         = 3'd3,
        REG_KV_Y         = 3'd4,
        REG_KV_Z         = 3'd5,
        REG_ACCEL_LIMIT  = 3'd6
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RST  = 24'd65536;
    localparam logic [GAIN_W-1:0] LIMIT_RST = 24'd327680;

    // Per-request data that rides along the norm and divide stages
    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
        logic [2:0][NUM_W-1:0]   num;
        logic [2:0][IN_W-1:0]    ff;
        logic                    lim;
    } t_carry;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  low;
    } t_div_ax;

    typedef struct packed {
        logic [ROOT_W-1:0] norm;
        t_div_ax [2:0]     ax;
    } t_div_st;

endpackage

// ===== sv/pdnl_if.sv =====
// Channel interfaces of the PD acceleration command block:
// command requests, acceleration results and register writes.
// Depends on pdnl_pkg.
interface pdnl_cmd_if;
    logic                             valid;
    logic                             ready;
    logic signed [pdnl_pkg::IN_W-1:0] pos_err_x;
    logic signed [pdnl_pkg::IN_W-1:0] pos_err_y;
    logic signed [pdnl_pkg::IN_W-1:0] pos_err_z;
    logic signed [pdnl_pkg::IN_W-1:0] vel_err_x;
    logic signed [pdnl_pkg::IN_W-1:0] vel_err_y;
    logic signed [pdnl_pkg::IN_W-1:0] vel_err_z;
    logic signed [pdnl_pkg::IN_W-1:0] ff_acc_x;
    logic signed [pdnl_pkg::IN_W-1:0] ff_acc_y;
    logic signed [pdnl_pkg::IN_W-1:0] ff_acc_z;

    modport source (output valid, pos_err_x, pos_err_y, pos_err_z, vel_err_x, vel_err_y,
                    vel_err_z, ff_acc_x, ff_acc_y, ff_acc_z, input ready);
    modport sink   (input valid, pos_err_x, pos_err_y, pos_err_z, vel_err_x, vel_err_y,
                    vel_err_z, ff_acc_x, ff_acc_y, ff_acc_z, output ready);
endinterface

interface pdnl_acc_if #(parameter int DATA_WIDTH = pdnl_pkg::DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] acc_out_x;
    logic signed [DATA_WIDTH-1:0] acc_out_y;
    logic signed [DATA_WIDTH-1:0] acc_out_z;

    modport source (output valid, acc_out_x, acc_out_y, acc_out_z, input ready);
    modport sink   (input valid, acc_out_x, acc_out_y, acc_out_z, output ready);
endinterface

interface pdnl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pdnl_pkg::CFG_IDX_W-1:0]      index;
    logic [pdnl_pkg::GAIN_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pdnl_sqrt_step.sv =====
// One digit step of the integer square root: two radicand bits in,
// one root bit out. Depends on pdnl_pkg.
module pdnl_sqrt_step (
    input  pdnl_pkg::t_sqrt_st i_st,
    output pdnl_pkg::t_sqrt_st o_st
);
    import pdnl_pkg::*;

    logic [REM_W+1:0] w_rem2;
    logic [REM_W+1:0] w_trial;
    logic             w_ge;

    // Try the next root bit as one: remainder must cover 4*root + 1
    assign w_rem2  = {i_st.rem, i_st.rad[SQ_W-1 -: 2]};
    assign w_trial = {{(REM_W-ROOT_W){1'b0}}, i_st.root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    assign o_st.rem  = w_ge ? REM_W'(w_rem2 - w_trial) : REM_W'(w_rem2);
    assign o_st.root = {i_st.root[ROOT_W-2:0], w_ge};
    assign o_st.rad  = {i_st.rad[SQ_W-3:0], 2'b00};

endmodule

// ===== sv/pdnl_div_step.sv =====
// One restoring division step: shift in a dividend bit, subtract the norm
// when it fits, shift the quotient bit in. Depends on pdnl_pkg.
module pdnl_div_step (
    input  pdnl_pkg::t_div_ax         i_ax,
    input  logic [pdnl_pkg::ROOT_W-1:0] i_norm,
    output pdnl_pkg::t_div_ax         o_ax
);
    import pdnl_pkg::*;

    logic [DREM_W:0] w_rem2;
    logic            w_ge;

    assign w_rem2 = {i_ax.rem, i_ax.low[QUO_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, i_norm});

    assign o_ax.rem = w_ge ? DREM_W'(w_rem2 - {1'b0, i_norm}) : w_rem2[DREM_W-1:0];
    assign o_ax.low = {i_ax.low[QUO_W-2:0], w_ge};

endmodule

// ===== sv/pd_accel_command_norm_limit.sv =====
// PD acceleration command with feedback norm limit, top level.
// Depends on pdnl_pkg, pdnl_if, pdnl_sqrt_step and pdnl_div_step.
//
// Usage:
//   i_cmd carries one request per handshake: 3-axis position error, velocity
//   error and feedforward acceleration, signed Q16.16. o_acc returns one
//   acceleration per request in request order, saturated to DATA_WIDTH bits,
//   with gravity cancel added on z. i_cfg writes the gains and the norm limit
//   (index 0..6); it is always ready and should be used while no request is
//   in flight.
//   Between request accept and o_acc.valid lie 4 stages of gain multiply,
//   rounding and squaring, 32 square root stages (one root bit each), 24
//   divider stages (one quotient bit each), a final add and saturate stage
//   and the output register; every stage advances together.
//   Throughput is one request per cycle while i_cmd.ready is high.
//   When the receiver stalls, the output register holds its result and one
//   more result drops into a skid register; i_cmd.ready falls only while
//   that skid register is full, so nothing is lost or repeated.
//   Reset (synchronous, active low) empties the pipeline and restores the
//   register defaults: gains 1.0, limit 5.0.
module pd_accel_command_norm_limit #(
    parameter int DATA_WIDTH = pdnl_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pdnl_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdnl_cmd_if.sink    i_cmd,
    pdnl_cfg_if.sink    i_cfg,
    pdnl_acc_if.source  o_acc
);
    import pdnl_pkg::*;

    localparam int NST  = 4 + ROOT_W + QUO_W + 1;
    localparam int SW   = ((DATA_WIDTH > 35) ? DATA_WIDTH : 35) + 2;
    localparam longint GRAV = (981 * (longint'(1) << FRAC_BITS) + 50) / 100;
    localparam logic signed [SW-1:0] GRAV_SW = SW'(GRAV);
    localparam logic signed [SW-1:0] OUT_MAX =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] OUT_MIN = ~OUT_MAX;
    localparam logic signed [PROD_W:0] HALF = (PROD_W+1)'(1) <<< (FRAC_BITS-1);
    localparam logic signed [PROD_W:0] FB_MAX = 58'sd2147483647;
    localparam logic signed [PROD_W:0] FB_MIN = -58'sd2147483648;

    // Configuration registers
    logic [GAIN_W-1:0] r_kp [3];
    logic [GAIN_W-1:0] r_kv [3];
    logic [GAIN_W-1:0] r_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp[0] <= GAIN_RST;
            r_kp[1] <= GAIN_RST;
            r_kp[2] <= GAIN_RST;
            r_kv[0] <= GAIN_RST;
            r_kv[1] <= GAIN_RST;
            r_kv[2] <= GAIN_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KP_X:        r_kp[0] <= i_cfg.data;
                REG_KP_Y:        r_kp[1] <= i_cfg.data;
                REG_KP_Z:        r_kp[2] <= i_cfg.data;
                REG_KV_X:        r_kv[0] <= i_cfg.data;
                REG_KV_Y:        r_kv[1] <= i_cfg.data;
                REG_KV_Z:        r_kv[2] <= i_cfg.data;
                REG_ACCEL_LIMIT: r_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline control: all stages advance while the skid register is empty
    logic             w_en;
    logic [NST-1:0]   r_stv;
    logic             r_out_v;
    logic             r_skid_v;

    assign w_en        = !r_skid_v;
    assign i_cmd.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stv <= '0;
        end else if (w_en) begin
            r_stv <= {r_stv[NST-2:0], i_cmd.valid};
        end
    end

    // Stage 0: gain products
    logic signed [IN_W-1:0]   w_pe [3];
    logic signed [IN_W-1:0]   w_ve [3];
    logic        [IN_W-1:0]   w_ff [3];
    logic signed [PROD_W-1:0] r_pp [3];
    logic signed [PROD_W-1:0] r_vp [3];
    logic        [IN_W-1:0]   r0_ff [3];

    assign w_pe[0] = i_cmd.pos_err_x;
    assign w_pe[1] = i_cmd.pos_err_y;
    assign w_pe[2] = i_cmd.pos_err_z;
    assign w_ve[0] = i_cmd.vel_err_x;
    assign w_ve[1] = i_cmd.vel_err_y;
    assign w_ve[2] = i_cmd.vel_err_z;
    assign w_ff[0] = i_cmd.ff_acc_x;
    assign w_ff[1] = i_cmd.ff_acc_y;
    assign w_ff[2] = i_cmd.ff_acc_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_pp[a]  <= w_pe[a] * $signed({1'b0, r_kp[a]});
                r_vp[a]  <= w_ve[a] * $signed({1'b0, r_kv[a]});
                r0_ff[a] <= w_ff[a];
            end
        end
    end

    // Stage 1: round to Q.F and saturate the feedback
    logic signed [PROD_W:0]  w_rnd [3];
    logic signed [PROD_W:0]  w_sh  [3];
    logic signed [IN_W-1:0]  r_fb  [3];
    logic        [IN_W-1:0]  r1_ff [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_rnd[a] = (PROD_W+1)'(r_pp[a]) + (PROD_W+1)'(r_vp[a]) + HALF;
            w_sh[a]  = w_rnd[a] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                if (w_sh[a] > FB_MAX) begin
                    r_fb[a] <= FB_MAX[IN_W-1:0];
                end else if (w_sh[a] < FB_MIN) begin
                    r_fb[a] <= FB_MIN[IN_W-1:0];
                end else begin
                    r_fb[a] <= w_sh[a][IN_W-1:0];
                end
                r1_ff[a] <= r0_ff[a];
            end
        end
    end

    // Stage 2: magnitudes, squares, scale numerators and squared limit
    logic [MAG_W-1:0]    w_mag [3];
    logic [SQ_W-1:0]     r_sq  [3];
    logic [2*GAIN_W-1:0] r_lim2;
    t_carry              r2_cy;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = r_fb[a][IN_W-1] ? (~r_fb[a] + 1'b1) : r_fb[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_sq[a]       <= w_mag[a] * w_mag[a];
                r2_cy.num[a]  <= w_mag[a] * r_limit;
                r2_cy.mag[a]  <= w_mag[a];
                r2_cy.neg[a]  <= r_fb[a][IN_W-1];
                r2_cy.ff[a]   <= r1_ff[a];
            end
            r2_cy.lim <= 1'b0;
            r_lim2    <= r_limit * r_limit;
        end
    end

    // Stage 3: sum of squares and limit test
    t_sqrt_st r3_sq;
    t_carry   r3_cy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sq.rad  <= r_sq[0] + r_sq[1] + r_sq[2];
            r3_sq.rem  <= '0;
            r3_sq.root <= '0;
            r3_cy.neg  <= r2_cy.neg;
            r3_cy.mag  <= r2_cy.mag;
            r3_cy.num  <= r2_cy.num;
            r3_cy.ff   <= r2_cy.ff;
            r3_cy.lim  <= (r_sq[0] + r_sq[1] + r_sq[2]) > SQ_W'(r_lim2);
        end
    end

    // Square root stages, one root bit each
    t_sqrt_st r_sqs [ROOT_W];
    t_carry   r_scy [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        t_sqrt_st w_in;
        t_sqrt_st w_out;
        t_carry   w_cin;
        if (g == 0) begin : g_first
            assign w_in  = r3_sq;
            assign w_cin = r3_cy;
        end else begin : g_next
            assign w_in  = r_sqs[g-1];
            assign w_cin = r_scy[g-1];
        end
        pdnl_sqrt_step u_step (.i_st(w_in), .o_st(w_out));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sqs[g] <= w_out;
                r_scy[g] <= w_cin;
            end
        end
    end

    // Divider setup: high dividend bits start the remainder
    t_div_st w_dv_init;

    always_comb begin
        w_dv_init.norm = r_sqs[ROOT_W-1].root;
        for (int a = 0; a < 3; a++) begin
            w_dv_init.ax[a].rem = r_scy[ROOT_W-1].num[a][NUM_W-1 -: DREM_W];
            w_dv_init.ax[a].low = r_scy[ROOT_W-1].num[a][QUO_W-1:0];
        end
    end

    // Divider stages, one quotient bit per axis each
    t_div_st r_dv  [QUO_W];
    t_carry  r_dcy [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        t_div_st w_in;
        t_div_st w_out;
        t_carry  w_cin;
        if (g == 0) begin : g_first
            assign w_in  = w_dv_init;
            assign w_cin = r_scy[ROOT_W-1];
        end else begin : g_next
            assign w_in  = r_dv[g-1];
            assign w_cin = r_dcy[g-1];
        end
        assign w_out.norm = w_in.norm;
        for (genvar a = 0; a < 3; a++) begin : g_ax
            pdnl_div_step u_step (.i_ax(w_in.ax[a]), .i_norm(w_in.norm), .o_ax(w_out.ax[a]));
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[g]  <= w_out;
                r_dcy[g] <= w_cin;
            end
        end
    end

    // Final stage: pick the scaled or raw magnitude, restore sign, add feedforward and gravity on z, saturate
    t_carry                  w_fc;
    logic        [MAG_W-1:0] w_val [3];
    logic signed [SW-1:0]    w_sv  [3];
    logic signed [SW-1:0]    w_tot [3];
    logic signed [DATA_WIDTH-1:0] r_fin [3];

    assign w_fc = r_dcy[QUO_W-1];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_val[a] = w_fc.lim ? MAG_W'(r_dv[QUO_W-1].ax[a].low) : w_fc.mag[a];
            w_sv[a]  = $signed({{(SW-MAG_W){1'b0}}, w_val[a]});
            w_tot[a] = (w_fc.neg[a] ? -w_sv[a] : w_sv[a]) + SW'($signed(w_fc.ff[a]))
                       + ((a == 2) ? GRAV_SW : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                if (w_tot[a] > OUT_MAX) begin
                    r_fin[a] <= OUT_MAX[DATA_WIDTH-1:0];
                end else if (w_tot[a] < OUT_MIN) begin
                    r_fin[a] <= OUT_MIN[DATA_WIDTH-1:0];
                end else begin
                    r_fin[a] <= w_tot[a][DATA_WIDTH-1:0];
                end
            end
        end
    end

    // Output register and skid register
    logic signed [DATA_WIDTH-1:0] r_out  [3];
    logic signed [DATA_WIDTH-1:0] r_skid [3];
    logic                         w_take;

    assign w_take = r_out_v && o_acc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (!r_out_v || w_take) begin
                r_out_v <= r_stv[NST-1];
            end else if (r_stv[NST-1]) begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_v || w_take) begin
                r_out <= r_fin;
            end else begin
                r_skid <= r_fin;
            end
        end else if (w_take) begin
            r_out <= r_skid;
        end
    end

    assign o_acc.valid     = r_out_v;
    assign o_acc.acc_out_x = r_out[0];
    assign o_acc.acc_out_y = r_out[1];
    assign o_acc.acc_out_z = r_out[2];

endmodule

// ===== sv/pdnl_checker.sv =====
// Port-level checks for the PD acceleration command block, with the bind
// that attaches them to the top level. Depends on pdnl_pkg.
module pdnl_checker #(
    parameter int DATA_WIDTH = pdnl_pkg::DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cmd_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] i_out_x,
    input logic [DATA_WIDTH-1:0] i_out_y,
    input logic [DATA_WIDTH-1:0] i_out_z
);
    import pdnl_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
        && $stable(i_out_y) && $stable(i_out_z))
        else $error("stalled result changed");

    // Drop results on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Accept requests whenever no result waits
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_cmd_ready)
        else $error("request refused with empty output");

    // Refuse requests only after a receiver stall
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_cmd_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("request refused without output stall");

endmodule

bind pd_accel_command_norm_limit pdnl_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pdnl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_out_valid (o_acc.valid),
    .i_out_ready (o_acc.ready),
    .i_out_x     (o_acc.acc_out_x),
    .i_out_y     (o_acc.acc_out_y),
    .i_out_z     (o_acc.acc_out_z)
);
